[rtl/core/rfpe_pkg.sv]
// ----------------------------------------------------------------------------
// rfpe_pkg
// Shared types and constants for the remote frame pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfpe_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_US      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTE       = 2'd2;

  // Register reset values.
  localparam logic [23:0] ADDRESS_RESET = 24'd0;
  localparam logic [11:0] SYMBOL_RESET  = 12'd640;
  localparam logic [7:0]  KEY_RESET     = 8'hA7;

  // Fixed pulse durations in microseconds.
  localparam logic [16:0] WAKE_MARK_US      = 17'd9415;
  localparam logic [16:0] WAKE_SPACE_US     = 17'd89565;
  localparam logic [16:0] SOFT_SYNC_MARK_US = 17'd4550;
  localparam logic [14:0] GAP_US            = 15'd30415;

  // Frame geometry and sync counts.
  localparam int unsigned FRAME_BITS = 56;
  localparam logic [5:0]  LAST_BIT   = 6'd55;
  localparam logic [2:0]  SYNC_FIRST = 3'd2;
  localparam logic [2:0]  SYNC_REPEAT = 3'd7;

  // One frame request.
  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] rolling_code;
    logic        first_frame;
  } in_item_t;

  // One timed pulse pair.
  typedef struct packed {
    logic        lead_is_mark;
    logic [16:0] lead_us;
    logic [16:0] follow_us;
    logic [14:0] tail_space_us;
    logic        last;
  } out_item_t;

  // An encoded frame waiting for transmission.
  typedef struct packed {
    logic                  first_frame;
    logic [FRAME_BITS-1:0] bits;
  } frame_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[rtl/core/rts_remote_frame_pulse_encoder_top.sv]
// ----------------------------------------------------------------------------
// rts_remote_frame_pulse_encoder_top
// Encodes remote-control frame requests into timed radio pulse pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at a
//   clock edge where start is high and busy is low. busy is high while the
//   two-entry frame queue is full.
//   Result channel: each pulse pair appears on out_item for one cycle with
//   out_strobe high. The receiver cannot stall, so it must take every pair.
//   Configuration: cfg_we with cfg_index 0 (address), 1 (symbol length) or
//   2 (key byte) writes cfg_wdata; write only while the block is idle.
// Timing:
//   When the sequencer is idle, a taken item passes through the queue entry,
//   the sequencer state and the output register before its first pair leaves.
//   The sequencer emits one pair per cycle; a first frame has 60 pairs and any
//   other frame 64; with a frame queued the next one follows the last pair with no gap.
// Reset:
//   Synchronous, active low: the queue empties, the sequencer idles and the
//   registers return to address 0, symbol 640 us and key 0xA7.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_remote_frame_pulse_encoder_top import rfpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_strobe,
  output out_item_t                  out_item
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  frame_t        push_frame;
  frame_t        pop_frame;
  logic [11:0]   symbol_us;

  // Front end: registers and frame encoding.
  rfpe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .item       (in_item),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame),
    .symbol_us  (symbol_us)
  );

  // Frame queue between the two ends.
  rfpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  // Back end: pulse sequencer.
  rfpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_frame  (pop_frame),
    .symbol_us  (symbol_us),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  assign busy = q_status.full;

endmodule

`default_nettype wire

[rtl/core/rfpe_front.sv]
// ----------------------------------------------------------------------------
// rfpe_front
// Holds the configuration registers, accepts frame requests and encodes
// each into a 56-bit obfuscated frame for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpe_front import rfpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  start,
  input  wire in_item_t              item,
  input  wire queue_status_t         q_status,
  output logic                       push,
  output frame_t                     push_frame,
  output logic [11:0]                symbol_us
);

  logic [23:0] address_r;
  logic [11:0] symbol_r;
  logic [7:0]  key_r;
  logic [7:0]  raw [7];
  logic [7:0]  obf [7];
  logic [3:0]  csum;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r <= ADDRESS_RESET;
      symbol_r  <= SYMBOL_RESET;
      key_r     <= KEY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REMOTE_ADDRESS: address_r <= cfg_wdata;
        CFG_SYMBOL_US:      symbol_r  <= cfg_wdata[11:0];
        CFG_KEY_BYTE:       key_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign symbol_us = symbol_r;

  // Checksum is the XOR of every nibble with the checksum slot at zero.
  assign csum = key_r[7:4] ^ key_r[3:0] ^ item.command
              ^ item.rolling_code[15:12] ^ item.rolling_code[11:8]
              ^ item.rolling_code[7:4] ^ item.rolling_code[3:0]
              ^ address_r[23:20] ^ address_r[19:16] ^ address_r[15:12]
              ^ address_r[11:8] ^ address_r[7:4] ^ address_r[3:0];

  // Plain frame bytes, then chained XOR obfuscation.
  always_comb begin
    raw[0] = key_r;
    raw[1] = {item.command, csum};
    raw[2] = item.rolling_code[15:8];
    raw[3] = item.rolling_code[7:0];
    raw[4] = address_r[23:16];
    raw[5] = address_r[15:8];
    raw[6] = address_r[7:0];
    obf[0] = raw[0];
    for (int i = 1; i < 7; i++) begin
      obf[i] = raw[i] ^ obf[i-1];
    end
  end

  // A request is taken whenever the queue has room.
  assign push                   = start && !q_status.full;
  assign push_frame.first_frame = item.first_frame;
  assign push_frame.bits        = {obf[0], obf[1], obf[2], obf[3], obf[4], obf[5], obf[6]};

endmodule

`default_nettype wire

[rtl/core/rfpe_queue.sv]
// ----------------------------------------------------------------------------
// rfpe_queue
// Two-entry queue of encoded frames between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpe_queue import rfpe_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire frame_t  push_frame,
  input  wire logic    pop,
  output frame_t       pop_frame,
  output queue_status_t status
);

  logic   [1:0] count_r;
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  frame_t       entry_r [2];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_frame;
  end

  assign pop_frame    = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  // A full queue is never written and an empty one never read.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push) else $error("push into full frame queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop) else $error("pop from empty frame queue");

endmodule

`default_nettype wire

[rtl/core/rfpe_back.sv]
// ----------------------------------------------------------------------------
// rfpe_back
// Pulse sequencer: turns one queued frame into wake-up (first frames only),
// sync and Manchester data pulse pairs, one pair per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpe_back import rfpe_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire queue_status_t q_status,
  input  wire frame_t        pop_frame,
  input  wire logic [11:0]   symbol_us,
  output logic               pop,
  output logic               out_strobe,
  output out_item_t          out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAKE,
    ST_HSYNC,
    ST_SSYNC,
    ST_DATA
  } state_t;

  state_t                state_r, state_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic                  strobe_r;
  out_item_t             item_r, item_nxt;
  logic [16:0]           sym17;
  logic [16:0]           sync17;
  logic                  frame_done;

  assign sym17      = {5'd0, symbol_us};
  assign sync17     = {3'd0, symbol_us, 2'b00};
  assign frame_done = (state_r == ST_DATA) && (cnt_r == LAST_BIT);
  assign pop        = ((state_r == ST_IDLE) || frame_done) && !q_status.empty;

  // Next state and the pair for the current step.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    item_nxt  = '0;
    case (state_r)
      ST_WAKE: begin
        item_nxt.lead_is_mark = 1'b1;
        item_nxt.lead_us      = WAKE_MARK_US;
        item_nxt.follow_us    = WAKE_SPACE_US;
        state_nxt             = ST_HSYNC;
        cnt_nxt               = {3'd0, SYNC_FIRST - 3'd1};
      end
      ST_HSYNC: begin
        item_nxt.lead_is_mark = 1'b1;
        item_nxt.lead_us      = sync17;
        item_nxt.follow_us    = sync17;
        if (cnt_r == 6'd0) begin
          state_nxt = ST_SSYNC;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      ST_SSYNC: begin
        item_nxt.lead_is_mark = 1'b1;
        item_nxt.lead_us      = SOFT_SYNC_MARK_US;
        item_nxt.follow_us    = sym17;
        state_nxt             = ST_DATA;
        cnt_nxt               = 6'd0;
      end
      ST_DATA: begin
        // A one bit is space then mark, a zero bit mark then space.
        item_nxt.lead_is_mark = !shift_r[FRAME_BITS-1];
        item_nxt.lead_us      = sym17;
        item_nxt.follow_us    = sym17;
        item_nxt.last         = frame_done;
        item_nxt.tail_space_us = frame_done ? GAP_US : 15'd0;
        shift_nxt             = {shift_r[FRAME_BITS-2:0], 1'b0};
        cnt_nxt               = cnt_r + 6'd1;
        if (frame_done) state_nxt = ST_IDLE;
      end
      default: ;
    endcase

    // A waiting frame is loaded from idle, or right after the last bit.
    if (pop) begin
      shift_nxt = pop_frame.bits;
      if (pop_frame.first_frame) begin
        state_nxt = ST_WAKE;
      end else begin
        state_nxt = ST_HSYNC;
        cnt_nxt   = {3'd0, SYNC_REPEAT - 3'd1};
      end
    end
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= 6'd0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= (state_r != ST_IDLE);
    end
    shift_r <= shift_nxt;
    item_r  <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  // The last data bit always comes out as the final, gapped pair.
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> out_strobe && out_item.last && out_item.tail_space_us == GAP_US)
    else $error("final pair missing after last data bit");
  a_last_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> $past(state_r) == ST_DATA)
    else $error("final pair flagged outside data phase");

endmodule

`default_nettype wire

[sim/rts_remote_frame_pulse_encoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_remote_frame_pulse_encoder_top_tb
// Self-checking bench for the remote frame pulse encoder. Frame requests are
// queued by a phase sequencer and presented by a clocked driver. A monitor
// builds the expected pulse pairs for every accepted item and compares each
// strobed pair with them, field by field, in order. Register settings change
// between phases, once the encoder has gone idle.
// ----------------------------------------------------------------------------

module rts_remote_frame_pulse_encoder_top_tb;
  import rfpe_pkg::*;

  // Button codes of the command nibble.
  localparam logic [3:0] CMD_STOP = 4'h1;
  localparam logic [3:0] CMD_UP   = 4'h2;
  localparam logic [3:0] CMD_DOWN = 4'h4;
  localparam logic [3:0] CMD_PROG = 4'h8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REMOTE_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_strobe;
  out_item_t             out_item;

  // Frame requests waiting for the driver, and pulse pairs still to come.
  in_item_t    pending_frames[$];
  out_item_t   expected_pairs[$];
  int unsigned sender_idle_pct = 13;
  int unsigned error_count     = 0;

  // Shadow copy of the encoder registers.
  logic [23:0] address_reg = ADDRESS_RESET;
  logic [11:0] symbol_reg  = SYMBOL_RESET;
  logic [7:0]  key_reg     = KEY_RESET;

  rts_remote_frame_pulse_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // 50 MHz clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic out_item_t make_pair(input logic mark, input logic [16:0] lead,
                                          input logic [16:0] follow,
                                          input logic [14:0] tail, input logic fin);
    out_item_t p;
    p.lead_is_mark  = mark;
    p.lead_us       = lead;
    p.follow_us     = follow;
    p.tail_space_us = tail;
    p.last          = fin;
    return p;
  endfunction

  // Builds the obfuscated frame for one request and queues its pulse pairs.
  task automatic encode_frame(input in_item_t req);
    logic [7:0]  fr [7];
    logic [3:0]  csum;
    logic [16:0] sync_us;
    logic [16:0] sym_us;
    int unsigned nsync;
    int          i;
    logic        bit_val;
    fr[0] = key_reg;
    fr[1] = {req.command, 4'h0};
    fr[2] = req.rolling_code[15:8];
    fr[3] = req.rolling_code[7:0];
    fr[4] = address_reg[23:16];
    fr[5] = address_reg[15:8];
    fr[6] = address_reg[7:0];
    // Checksum is the XOR of all nibbles with the checksum nibble still zero.
    csum = 4'h0;
    for (i = 0; i < 7; i++) begin
      csum ^= fr[i][7:4] ^ fr[i][3:0];
    end
    fr[1][3:0] = csum;
    // Chained obfuscation: each byte XORed with the already obfuscated one.
    for (i = 1; i < 7; i++) begin
      fr[i] = fr[i] ^ fr[i-1];
    end
    sym_us  = {5'd0, symbol_reg};
    sync_us = {3'd0, symbol_reg, 2'b00};
    if (req.first_frame) begin
      expected_pairs.push_back(make_pair(1'b1, WAKE_MARK_US, WAKE_SPACE_US, '0, 1'b0));
      nsync = SYNC_FIRST;
    end else begin
      nsync = SYNC_REPEAT;
    end
    for (i = 0; i < int'(nsync); i++) begin
      expected_pairs.push_back(make_pair(1'b1, sync_us, sync_us, '0, 1'b0));
    end
    expected_pairs.push_back(make_pair(1'b1, SOFT_SYNC_MARK_US, sym_us, '0, 1'b0));
    // Manchester data, MSB of byte 0 first; a one bit leads with space.
    for (i = 0; i < int'(FRAME_BITS); i++) begin
      bit_val = fr[i / 8][7 - (i % 8)];
      if (i == int'(FRAME_BITS) - 1) begin
        expected_pairs.push_back(make_pair(~bit_val, sym_us, sym_us, GAP_US, 1'b1));
      end else begin
        expected_pairs.push_back(make_pair(~bit_val, sym_us, sym_us, '0, 1'b0));
      end
    end
  endtask

  // Driver: presents queued requests, holds each until taken, idles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        void'(pending_frames.pop_front());
      end
      if (pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_item <= pending_frames[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted item and checks each strobed pair.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (start && !busy) begin
        encode_frame(in_item);
      end
      if (out_strobe) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("pulse pair with no frame pending");
        end else begin
          want = expected_pairs.pop_front();
          if (out_item.lead_is_mark !== want.lead_is_mark)
            report_mismatch($sformatf("lead_is_mark got %0b want %0b",
                                      out_item.lead_is_mark, want.lead_is_mark));
          if (out_item.lead_us !== want.lead_us)
            report_mismatch($sformatf("lead_us got %0d want %0d",
                                      out_item.lead_us, want.lead_us));
          if (out_item.follow_us !== want.follow_us)
            report_mismatch($sformatf("follow_us got %0d want %0d",
                                      out_item.follow_us, want.follow_us));
          if (out_item.tail_space_us !== want.tail_space_us)
            report_mismatch($sformatf("tail_space_us got %0d want %0d",
                                      out_item.tail_space_us, want.tail_space_us));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b",
                                      out_item.last, want.last));
        end
      end
    end
  end

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_REMOTE_ADDRESS: address_reg = value[23:0];
      CFG_SYMBOL_US:      symbol_reg  = value[11:0];
      CFG_KEY_BYTE:       key_reg     = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic [23:0] address, input logic [11:0] symbol,
                               input logic [7:0] key);
    write_register(CFG_REMOTE_ADDRESS, CFG_DATA_W'(address));
    write_register(CFG_SYMBOL_US, CFG_DATA_W'(symbol));
    write_register(CFG_KEY_BYTE, CFG_DATA_W'(key));
  endtask

  // Waits until every queued item is taken and every pair has come out.
  task automatic drain_frames();
    int waited;
    waited = 0;
    while (pending_frames.size() != 0) @(negedge clk);
    while (expected_pairs.size() != 0 && waited < 400) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (expected_pairs.size() != 0) begin
      report_mismatch($sformatf("%0d pulse pairs never arrived", expected_pairs.size()));
      expected_pairs.delete();
    end
  endtask

  // Queues random requests, mostly real buttons, and waits for them to drain.
  task automatic queue_random_frames(input int unsigned count);
    in_item_t req;
    logic [3:0] buttons [4];
    buttons = '{CMD_STOP, CMD_UP, CMD_DOWN, CMD_PROG};
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 70) begin
        req.command = buttons[$urandom_range(3)];
      end else begin
        req.command = 4'($urandom_range(15));
      end
      req.rolling_code = 16'($urandom_range(16'hFFFF));
      req.first_frame  = 1'($urandom_range(1));
      pending_frames.push_back(req);
    end
    drain_frames();
  endtask

  // Phase sequencer: reset, directed frames, then random frames per setting.
  initial begin
    in_item_t req;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command nibble at reset settings, then code extremes.
    sender_idle_pct = 13;
    for (int c = 0; c < 16; c++) begin
      req.command      = 4'(c);
      req.rolling_code = (c % 2 == 0) ? 16'h5555 : 16'hAAAA;
      req.first_frame  = c[0];
      pending_frames.push_back(req);
    end
    req = '{command: CMD_UP, rolling_code: 16'h0000, first_frame: 1'b1};
    pending_frames.push_back(req);
    req = '{command: CMD_DOWN, rolling_code: 16'hFFFF, first_frame: 1'b0};
    pending_frames.push_back(req);
    req = '{command: 4'hF, rolling_code: 16'hFFFF, first_frame: 1'b1};
    pending_frames.push_back(req);
    req = '{command: 4'h0, rolling_code: 16'h0000, first_frame: 1'b0};
    pending_frames.push_back(req);
    drain_frames();

    // Upper extremes of all registers.
    set_registers(24'hFFFFFF, 12'd4095, 8'hFF);
    queue_random_frames(30);

    // Lower extremes, with the sender mostly idle.
    sender_idle_pct = 78;
    set_registers(24'h000000, 12'd1, 8'h00);
    queue_random_frames(30);

    // A zero symbol length is taken as it is.
    set_registers(24'($urandom_range(24'hFFFFFF)), 12'd0, 8'($urandom_range(255)));
    queue_random_frames(25);

    // Random settings with back-to-back requests.
    sender_idle_pct = 0;
    for (int p = 0; p < 4; p++) begin
      set_registers(24'($urandom_range(24'hFFFFFF)), 12'($urandom_range(4095, 1)),
                    8'($urandom_range(255)));
      queue_random_frames(30);
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/core/rfpe_pkg.sv
rtl/core/rfpe_front.sv
rtl/core/rfpe_queue.sv
rtl/core/rfpe_back.sv
rtl/core/rts_remote_frame_pulse_encoder_top.sv
sim/rts_remote_frame_pulse_encoder_top_tb.sv
